>>> src/cpr_pkg.sv
// Shared types, constants and pin table of the charlieplexed row PWM core.
`default_nettype none
package cpr_pkg;

  // Number of charlieplex rows in one frame and the width of the row index.
  localparam int ROWS  = 4;
  localparam int ROW_W = $clog2(ROWS);

  // Last row of a frame; the index wraps to zero after it.
  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);

  // Reset value of the brightness clamp register.
  localparam logic [7:0] SAMPLE_LIMIT_RST = 8'd159;

  // Number of LEDs served by one row.
  localparam int LEDS = 3;

  // Port pin of each row.
  localparam logic [7:0] PIN_MASK [ROWS] = '{8'h02, 8'h04, 8'h08, 8'h40};

  // One row evaluation, as it is held in the result register.
  typedef struct packed {
    logic [7:0] drive_mask;
    logic [7:0] match_first;
    logic [7:0] match_second;
    logic [7:0] match_third;
    logic [7:0] dir_first;
    logic [7:0] dir_second;
    logic [7:0] dir_third;
    logic       lit;
  } cpr_result_t;

  // Sink mask of LED k in row r: the row's drive pin ORed with the k-th of
  // the other pins, taken in ascending row order.
  function automatic logic [7:0] led_mask(input logic [ROW_W-1:0] row,
                                          input logic [1:0] k);
    logic [7:0] mask;
    logic [1:0] j;
    mask = 8'h00;
    j    = 2'd0;
    for (int p = 0; p < ROWS; p++) begin
      if (ROW_W'(p) != row) begin
        if (j == k) begin
          mask = PIN_MASK[row] | PIN_MASK[p];
        end
        j = j + 2'd1;
      end
    end
    return mask;
  endfunction

endpackage
`default_nettype wire

>>> src/charlieplex_sorted_pwm_row_core.sv
// Top level of the charlieplexed row PWM core: row state and result register.
//
// Each input transfer is one PWM-period overflow for the current row. It
// carries the three LED samples on in_tdata and the active and end-of-wave
// flags on in_tuser. The core clamps the samples to sample_limit, sorts the
// three LEDs by brightness and returns one result transfer with the row
// drive mask, the three compare values and the cumulative direction masks,
// plus lit and the end-of-frame idle pulse on out_tuser.
// The sort and mask logic sits between the input handshake and a single
// result register, so a result appears in the cycle after its input transfer
// and one item is taken every cycle while the receiver keeps taking results.
// The core keeps accepting while a result waits, as long as the receiver takes
// that result in the same cycle; when out_tready is low with a result pending,
// in_tready drops and the held result stays unchanged. Reset sets the row
// index to zero, clears the frame's wave flag, empties the result register and
// loads sample_limit with 159. cfg_wr_en writes the limit at any clock edge;
// the user must change it only while the core is idle; the core does not check.
`default_nettype none
module charlieplex_sorted_pwm_row_core
  import cpr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Configuration: sample_limit
  input  wire logic        cfg_wr_en,
  input  wire logic [7:0]  cfg_wr_data,
  // Input channel
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // sample_a, sample_b, sample_c
  input  wire logic [5:0]  in_tuser,   // active_a, active_b, active_c,
                                       // ends_a, ends_b, ends_c
  // Result channel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [55:0]      out_tdata,  // drive_mask, match_first, match_second,
                                       // match_third, dir_first, dir_second,
                                       // dir_third
  output logic [1:0]       out_tuser   // lit, frame_idle
);

  logic [7:0]       sample_limit_r;
  logic [ROW_W-1:0] row_index_r, row_index_nxt;
  logic             wave_seen_r, wave_seen_nxt;
  logic             out_valid_r, out_valid_nxt;
  cpr_result_t      result_r, result_nxt;
  logic             idle_r, idle_nxt;
  logic             seen;
  logic             in_xfer;
  logic             ws_any;

  assign in_tready = !out_valid_r || out_tready;
  assign in_xfer   = in_tvalid && in_tready;

  // Row evaluation on the incoming transfer.
  cpr_row_eval u_eval (
    .sample_a     (in_tdata[7:0]),
    .sample_b     (in_tdata[15:8]),
    .sample_c     (in_tdata[23:16]),
    .active       (in_tuser[2:0]),
    .ends         (in_tuser[5:3]),
    .sample_limit (sample_limit_r),
    .row          (row_index_r),
    .result       (result_nxt),
    .seen         (seen)
  );

  // Row advance and frame-end bookkeeping.
  always_comb begin
    ws_any        = wave_seen_r || seen;
    row_index_nxt = row_index_r;
    wave_seen_nxt = wave_seen_r;
    idle_nxt      = 1'b0;
    if (in_xfer) begin
      row_index_nxt = (row_index_r == LAST_ROW) ? '0 : row_index_r + 1'b1;
      wave_seen_nxt = ws_any;
      if (row_index_r == LAST_ROW) begin
        idle_nxt      = !ws_any;
        wave_seen_nxt = 1'b0;
      end
    end
  end

  // The result register fills on an input transfer and empties when taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_xfer) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control state and configuration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_limit_r <= SAMPLE_LIMIT_RST;
      row_index_r    <= '0;
      wave_seen_r    <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        sample_limit_r <= cfg_wr_data;
      end
      row_index_r <= row_index_nxt;
      wave_seen_r <= wave_seen_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      result_r <= result_nxt;
      idle_r   <= idle_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {result_r.dir_third, result_r.dir_second, result_r.dir_first,
                       result_r.match_third, result_r.match_second,
                       result_r.match_first, result_r.drive_mask};
  assign out_tuser  = {idle_r, result_r.lit};

endmodule
`default_nettype wire

>>> src/cpr_row_eval.sv
// Combinational evaluation of one row: clamp, stable descending sort and masks.
`default_nettype none
module cpr_row_eval
  import cpr_pkg::*;
(
  input  wire logic [7:0]       sample_a,
  input  wire logic [7:0]       sample_b,
  input  wire logic [7:0]       sample_c,
  input  wire logic [2:0]       active,
  input  wire logic [2:0]       ends,
  input  wire logic [7:0]       sample_limit,
  input  wire logic [ROW_W-1:0] row,
  output cpr_result_t           result,
  output logic                  seen
);

  logic [7:0] v0, v1, v2;
  logic [7:0] s0, s1, s2;
  logic [7:0] m0, m1, m2;
  logic [7:0] t;

  // Clamp each sample to the limit; an inactive LED is dark.
  function automatic logic [7:0] clamp(input logic [7:0] s, input logic act,
                                       input logic [7:0] lim);
    logic [7:0] r;
    r = 8'h00;
    if (act) begin
      r = (s > lim) ? lim : s;
    end
    return r;
  endfunction

  assign v0 = clamp(sample_a, active[0], sample_limit);
  assign v1 = clamp(sample_b, active[1], sample_limit);
  assign v2 = clamp(sample_c, active[2], sample_limit);

  // A row counts as seen when any LED is lit or has a wave that keeps going.
  assign seen = ((v0 | v1 | v2) != 8'h00) || ((active & ~ends) != 3'b000);

  // Three compare-exchange steps keep equal values in their input order.
  always_comb begin
    t  = 8'h00;
    s0 = v0;
    s1 = v1;
    s2 = v2;
    m0 = led_mask(row, 2'd0);
    m1 = led_mask(row, 2'd1);
    m2 = led_mask(row, 2'd2);
    if (s1 < s2) begin
      t = s1; s1 = s2; s2 = t;
      t = m1; m1 = m2; m2 = t;
    end
    if (s0 < s1) begin
      t = s0; s0 = s1; s1 = t;
      t = m0; m0 = m1; m1 = t;
      if (s1 < s2) begin
        t = s1; s1 = s2; s2 = t;
        t = m1; m1 = m2; m2 = t;
      end
    end
  end

  // Dark LEDs drop out of the direction masks, which then accumulate.
  always_comb begin
    result = '0;
    if (s0 != 8'h00) begin
      result.drive_mask   = PIN_MASK[row];
      result.match_first  = 8'h00 - s0;
      result.match_second = 8'h00 - s1;
      result.match_third  = 8'h00 - s2;
      result.dir_first    = m0;
      result.dir_second   = m0 | ((s1 != 8'h00) ? m1 : 8'h00);
      result.dir_third    = m0 | ((s1 != 8'h00) ? m1 : 8'h00)
                               | ((s2 != 8'h00) ? m2 : 8'h00);
      result.lit          = 1'b1;
    end
  end

endmodule
`default_nettype wire

>>> src/cpr_checker.sv
// Port-level checker for the charlieplexed row PWM core, bound to the top level.
`default_nettype none
module cpr_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [55:0] out_tdata,
  input wire logic [1:0]  out_tuser
);

  // A stalled result holds its payload.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // An empty result register never blocks the input.
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input blocked with no result pending");

  // Every input transfer yields a result in the next cycle.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("input transfer produced no result");

  // A dark row reports all-zero drive, compare and direction fields.
  a_dark: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata == 56'h0)
    else $error("dark row with nonzero fields");

  // A lit row drives its pin and the direction masks only grow.
  a_lit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |->
      out_tdata[7:0] != 8'h00 && out_tdata[39:32] != 8'h00 &&
      (out_tdata[39:32] & ~out_tdata[47:40]) == 8'h00 &&
      (out_tdata[47:40] & ~out_tdata[55:48]) == 8'h00)
    else $error("lit row with inconsistent masks");

endmodule

bind charlieplex_sorted_pwm_row_core cpr_checker u_cpr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
`default_nettype wire

>>> tb/sv/testbench.sv
// Self-checking testbench for the charlieplexed row PWM core.
`default_nettype none
module testbench
  import cpr_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // One row event as it travels on the input channel.
  typedef struct packed {
    logic [2:0]      ends;     // bit k: end-of-wave flag of LED k
    logic [2:0]      active;   // bit k: LED k has a running wave
    logic [2:0][7:0] samples;  // [0] is the first LED of the row
  } pwm_event_t;

  // One row evaluation as it travels on the result channel.
  typedef struct packed {
    logic [7:0]      drive;
    logic [2:0][7:0] match;    // [0] brightest, [2] dimmest
    logic [2:0][7:0] dir;      // cumulative direction masks
    logic            lit;
    logic            idle;
  } row_result_t;

  // Directed stimulus row, with a hand-typed result where it is obvious.
  typedef struct packed {
    pwm_event_t  ev;
    logic        typed;
    row_result_t want;
  } stim_row_t;

  localparam int HOLD_CYCLES  = 48;
  localparam int QUIET_LIMIT  = 2000;
  localparam int PHASE_ITEMS  = 190;
  localparam int PHASES       = 6;

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [7:0]  cfg_wr_data;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;
  logic [5:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [55:0] out_tdata;
  logic [1:0]  out_tuser;

  // Copy of the core's state and register, advanced on each input transfer.
  logic [7:0]       pred_limit;
  logic [ROW_W-1:0] pred_row;
  logic             pred_seen;

  row_result_t pending_rows[$];
  stim_row_t   directed[$];

  int  errors;
  int  n_in;
  int  n_out;
  int  n_lit;
  int  n_idle;
  int  n_cfg;
  int  quiet_cycles;
  bit  idling_on;
  bit  hold_pending;
  bit  dark_frame;

  charlieplex_sorted_pwm_row_core i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic pwm_event_t make_event(logic [7:0] a, logic [7:0] b, logic [7:0] c,
                                            logic [2:0] act, logic [2:0] ends);
    pwm_event_t ev;
    ev.samples[0] = a;
    ev.samples[1] = b;
    ev.samples[2] = c;
    ev.active     = act;
    ev.ends       = ends;
    return ev;
  endfunction

  function automatic row_result_t make_result(logic [7:0] drive, logic [7:0] m0,
                                              logic [7:0] m1, logic [7:0] m2,
                                              logic [7:0] d0, logic [7:0] d1,
                                              logic [7:0] d2, logic lit, logic idle);
    row_result_t r;
    r.drive    = drive;
    r.match[0] = m0;
    r.match[1] = m1;
    r.match[2] = m2;
    r.dir[0]   = d0;
    r.dir[1]   = d1;
    r.dir[2]   = d2;
    r.lit      = lit;
    r.idle     = idle;
    return r;
  endfunction

  function automatic stim_row_t row_p(pwm_event_t ev);
    stim_row_t s;
    s.ev    = ev;
    s.typed = 1'b0;
    s.want  = '0;
    return s;
  endfunction

  function automatic stim_row_t row_t(pwm_event_t ev, row_result_t want);
    stim_row_t s;
    s.ev    = ev;
    s.typed = 1'b1;
    s.want  = want;
    return s;
  endfunction

  // Evaluate one row event against the current state and advance the state.
  function automatic row_result_t evaluate_row(pwm_event_t ev);
    logic [7:0]  bright [3];
    logic [7:0]  mask [3];
    int          order [3];
    int          tmp;
    int          j;
    int          p;
    int          k;
    int          pass;
    logic        seen;
    logic [7:0]  acc;
    row_result_t r;
    r = '0;
    j = 0;
    for (p = 0; p < ROWS; p++) begin
      if (p != int'(pred_row)) begin
        mask[j] = PIN_MASK[pred_row] | PIN_MASK[p];
        j++;
      end
    end
    // Clamp each sample; an LED without a running wave stays dark.
    for (k = 0; k < LEDS; k++) begin
      if (!ev.active[k]) begin
        bright[k] = 8'd0;
      end else if (ev.samples[k] > pred_limit) begin
        bright[k] = pred_limit;
      end else begin
        bright[k] = ev.samples[k];
      end
    end
    seen = (bright[0] != 0) || (bright[1] != 0) || (bright[2] != 0) ||
           ((ev.active & ~ev.ends) != 3'b000);
    // Stable descending order: swap only on strictly smaller values.
    order = '{0, 1, 2};
    for (pass = 0; pass < 2; pass++) begin
      for (k = 0; k < 2; k++) begin
        if (bright[order[k]] < bright[order[k+1]]) begin
          tmp = order[k];
          order[k] = order[k+1];
          order[k+1] = tmp;
        end
      end
    end
    // Dark LEDs contribute no mask; an all-dark row leaves everything zero.
    if (bright[order[0]] != 0) begin
      r.drive = PIN_MASK[pred_row];
      r.lit   = 1'b1;
      acc     = 8'h00;
      for (k = 0; k < LEDS; k++) begin
        if (bright[order[k]] != 0) begin
          acc = acc | mask[order[k]];
        end
        r.match[k] = 8'd0 - bright[order[k]];
        r.dir[k]   = acc;
      end
    end
    // Frame bookkeeping: the idle pulse closes a frame with no wave seen.
    if (seen) begin
      pred_seen = 1'b1;
    end
    if (pred_row == LAST_ROW) begin
      r.idle    = ~pred_seen;
      pred_seen = 1'b0;
    end
    pred_row = pred_row + 1'b1;
    return r;
  endfunction

  // Pick a sample that often sits on the clamp boundary or the byte extremes.
  function automatic logic [7:0] pick_sample(logic [7:0] neighbor);
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return pred_limit;
      2: return pred_limit + 8'd1;
      3: return 8'hFF;
      4: return neighbor;
      default: return 8'($urandom);
    endcase
  endfunction

  // Random row event; now and then a whole frame is kept free of waves.
  function automatic pwm_event_t random_event();
    pwm_event_t ev;
    int k;
    if (pred_row == '0) begin
      dark_frame = ($urandom_range(0, 5) == 0);
    end
    ev.samples[0] = pick_sample(8'($urandom));
    for (k = 1; k < LEDS; k++) begin
      ev.samples[k] = pick_sample(ev.samples[k-1]);
    end
    if (dark_frame) begin
      // Active LEDs only with zero samples and their wave ending.
      ev.active = 3'($urandom);
      for (k = 0; k < LEDS; k++) begin
        if (ev.active[k]) begin
          ev.samples[k] = 8'd0;
        end
      end
      ev.ends = ev.active | 3'($urandom);
    end else begin
      ev.active = ($urandom_range(0, 2) == 0) ? 3'($urandom) : 3'b111;
      for (k = 0; k < LEDS; k++) begin
        ev.ends[k] = ($urandom_range(0, 7) == 0);
      end
    end
    return ev;
  endfunction

  // Offer one event, with a random gap ahead of it, and log its expectation.
  task automatic offer_event(pwm_event_t ev, logic typed, row_result_t want);
    row_result_t predicted;
    @(negedge clk);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      in_tdata  <= 24'($urandom);
      in_tuser  <= 6'($urandom);
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= ev.samples;
    in_tuser  <= {ev.ends, ev.active};
    do @(posedge clk); while (!in_tready);
    predicted = evaluate_row(ev);
    pending_rows.push_back(typed ? want : predicted);
    n_in++;
  endtask

  // Stop offering and wait until every expected result has arrived.
  task automatic wait_results_done();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_rows.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Write the clamp register while the core is idle.
  task automatic write_sample_limit(logic [7:0] value);
    wait_results_done();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= 8'($urandom);
    pred_limit = value;
    n_cfg++;
  endtask

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, got %h", $realtime, name, want, got);
      errors++;
    end
  endtask

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_pending) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_pending = 1'b0;
      end else if (idling_on && $urandom_range(0, 4) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 13) - 1) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Result checker: every result transfer against the oldest expectation.
  always @(posedge clk) begin
    row_result_t want;
    row_result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.drive    = out_tdata[7:0];
      got.match[0] = out_tdata[15:8];
      got.match[1] = out_tdata[23:16];
      got.match[2] = out_tdata[31:24];
      got.dir[0]   = out_tdata[39:32];
      got.dir[1]   = out_tdata[47:40];
      got.dir[2]   = out_tdata[55:48];
      got.lit      = out_tuser[0];
      got.idle     = out_tuser[1];
      n_out++;
      if (got.lit) n_lit++;
      if (got.idle) n_idle++;
      if (pending_rows.size() == 0) begin
        $display("%0t: result transfer with none expected, got %h", $realtime, got);
        errors++;
      end else begin
        want = pending_rows.pop_front();
        check_field("drive_mask", want.drive, got.drive);
        check_field("match_first", want.match[0], got.match[0]);
        check_field("match_second", want.match[1], got.match[1]);
        check_field("match_third", want.match[2], got.match[2]);
        check_field("dir_first", want.dir[0], got.dir[0]);
        check_field("dir_second", want.dir[1], got.dir[1]);
        check_field("dir_third", want.dir[2], got.dir[2]);
        check_field("lit", 8'(want.lit), 8'(got.lit));
        check_field("frame_idle", 8'(want.idle), 8'(got.idle));
      end
    end
  end

  // Watchdog: too long without any transfer ends the run.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Main sequence: reset, directed rows, then random phases per clamp setting.
  initial begin
    logic [7:0] phase_limit [PHASES];
    int ph;
    int i;
    errors       = 0;
    n_in         = 0;
    n_out        = 0;
    n_lit        = 0;
    n_idle       = 0;
    n_cfg        = 0;
    quiet_cycles = 0;
    idling_on    = 1'b1;
    hold_pending = 1'b0;
    dark_frame   = 1'b0;
    pred_limit   = SAMPLE_LIMIT_RST;
    pred_row     = '0;
    pred_seen    = 1'b0;
    rst_n        = 1'b0;
    cfg_wr_en    = 1'b0;
    cfg_wr_data  = 8'h00;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = '0;

    // First frame: dark row, a clamped single LED, ties and mixed values.
    directed.push_back(row_t(make_event(8'h00, 8'h00, 8'h00, 3'b000, 3'b000),
                             make_result(8'h00, 8'h00, 8'h00, 8'h00,
                                         8'h00, 8'h00, 8'h00, 1'b0, 1'b0)));
    directed.push_back(row_t(make_event(8'hFF, 8'h00, 8'h00, 3'b001, 3'b000),
                             make_result(8'h04, 8'h61, 8'h00, 8'h00,
                                         8'h06, 8'h06, 8'h06, 1'b1, 1'b0)));
    directed.push_back(row_p(make_event(8'd100, 8'd100, 8'd100, 3'b111, 3'b000)));
    directed.push_back(row_p(make_event(8'hFF, 8'h00, 8'h80, 3'b111, 3'b111)));
    // Second frame: no wave at all, so its last row raises the idle pulse.
    directed.push_back(row_t(make_event(8'hFF, 8'hFF, 8'hFF, 3'b000, 3'b111),
                             make_result(8'h00, 8'h00, 8'h00, 8'h00,
                                         8'h00, 8'h00, 8'h00, 1'b0, 1'b0)));
    directed.push_back(row_t(make_event(8'h00, 8'h00, 8'h00, 3'b111, 3'b111),
                             make_result(8'h00, 8'h00, 8'h00, 8'h00,
                                         8'h00, 8'h00, 8'h00, 1'b0, 1'b0)));
    directed.push_back(row_t(make_event(8'hAA, 8'h55, 8'h12, 3'b000, 3'b000),
                             make_result(8'h00, 8'h00, 8'h00, 8'h00,
                                         8'h00, 8'h00, 8'h00, 1'b0, 1'b0)));
    directed.push_back(row_t(make_event(8'h00, 8'h00, 8'h00, 3'b000, 3'b000),
                             make_result(8'h00, 8'h00, 8'h00, 8'h00,
                                         8'h00, 8'h00, 8'h00, 1'b0, 1'b1)));
    // Third frame: an active but zero LED still counts as a wave.
    directed.push_back(row_t(make_event(8'h00, 8'h00, 8'h00, 3'b111, 3'b000),
                             make_result(8'h00, 8'h00, 8'h00, 8'h00,
                                         8'h00, 8'h00, 8'h00, 1'b0, 1'b0)));
    directed.push_back(row_p(make_event(8'd160, 8'd159, 8'd158, 3'b111, 3'b000)));
    directed.push_back(row_p(make_event(8'd1, 8'd2, 8'd3, 3'b111, 3'b000)));
    directed.push_back(row_p(make_event(8'd3, 8'd0, 8'h10, 3'b101, 3'b000)));
    // Fourth and fifth frames: partial darkness, ends flags and full scale.
    directed.push_back(row_p(make_event(8'd0, 8'd5, 8'd5, 3'b111, 3'b010)));
    directed.push_back(row_p(make_event(8'd1, 8'd0, 8'd0, 3'b001, 3'b000)));
    directed.push_back(row_p(make_event(8'h00, 8'h00, 8'h9F, 3'b100, 3'b100)));
    directed.push_back(row_p(make_event(8'h7F, 8'h80, 8'h9F, 3'b111, 3'b111)));
    directed.push_back(row_p(make_event(8'hFF, 8'hFF, 8'hFF, 3'b111, 3'b000)));
    directed.push_back(row_p(make_event(8'h9F, 8'hA0, 8'h00, 3'b011, 3'b001)));
    directed.push_back(row_p(make_event(8'h00, 8'h9E, 8'hFF, 3'b110, 3'b000)));
    directed.push_back(row_p(make_event(8'h01, 8'h01, 8'h02, 3'b111, 3'b000)));

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) begin
      offer_event(directed[i].ev, directed[i].typed, directed[i].want);
    end

    // Clamp settings: both extremes, one near zero, random, mid-scale and the reset value.
    phase_limit = '{8'hFF, 8'h00, 8'h01, 8'($urandom), 8'h80, SAMPLE_LIMIT_RST};
    for (ph = 0; ph < PHASES; ph++) begin
      write_sample_limit(phase_limit[ph]);
      idling_on = (ph != PHASES - 1);
      if (ph == 1) begin
        // Long receiver hold-off while events keep coming.
        hold_pending = 1'b1;
      end
      for (i = 0; i < PHASE_ITEMS; i++) begin
        if (ph == 3 && i == PHASE_ITEMS / 2) begin
          wait_results_done();
        end
        offer_event(random_event(), 1'b0, '0);
      end
    end

    wait_results_done();
    repeat (4) @(posedge clk);
    if (pending_rows.size() != 0) begin
      $display("%0t: %0d results never arrived", $realtime, pending_rows.size());
      errors += pending_rows.size();
    end
    $display("Covered %0d row events and %0d results (%0d lit rows, %0d idle frames)",
             n_in, n_out, n_lit, n_idle);
    $display("across %0d sample limit settings, with stalls on both channels.", n_cfg);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
`default_nettype wire
